/* sv/sfsc_pkg.sv */
`default_nettype none

package sfsc_pkg;

    // Header bytes that open a frame, oldest first.
    localparam logic [7:0] HDR0 = 8'h16;
    localparam logic [7:0] HDR1 = 8'h09;
    localparam logic [7:0] HDR2 = 8'h01;

    // Ten payload bytes follow the header, then one checksum byte.
    localparam int unsigned PAYLOAD_LEN = 10;
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] LAST_PAYLOAD_IDX = IDX_W'(PAYLOAD_LEN);

    // The window counts fresh bytes up to two.
    localparam logic [1:0] WINDOW_FULL = 2'd2;

    // Frame status codes.
    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef logic [7:0] byte_t;

    // Payload bytes, entry 0 is frame byte 3.
    typedef logic [PAYLOAD_LEN-1:0][7:0] field_array_t;

    // One result word handed from the frame core to the result register.
    typedef struct packed {
        logic         status;
        field_array_t fields;
    } result_t;

endpackage

`default_nettype wire

/* sv/sfsc_input_stage.sv */
`default_nettype none

module sfsc_input_stage (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  in_valid,
    output logic in_stall,
    input  wire  sfsc_pkg::byte_t rx_byte,
    input  wire  consume,
    output logic byte_valid,
    output sfsc_pkg::byte_t byte_data
);

    logic            valid_reg;
    logic            valid_next;
    sfsc_pkg::byte_t byte_reg;
    logic            load;

    // The register takes a new word when it is empty or its word leaves now.
    assign in_stall = valid_reg && !consume;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

/* sv/sfsc_frame_core.sv */
`default_nettype none

module sfsc_frame_core (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  advance,
    input  wire  sfsc_pkg::byte_t byte_data,
    output logic frame_done,
    output sfsc_pkg::result_t result
);

    logic [15:0]                  sync_window_reg;
    logic [15:0]                  sync_window_next;
    logic [1:0]                   window_fill_reg;
    logic [1:0]                   window_fill_next;
    logic                         collecting_reg;
    logic                         collecting_next;
    logic [sfsc_pkg::IDX_W-1:0]   byte_index_reg;
    logic [sfsc_pkg::IDX_W-1:0]   byte_index_next;
    logic [7:0]                   sum_reg;
    logic [7:0]                   sum_next;
    sfsc_pkg::field_array_t       payload_buffer_reg;
    sfsc_pkg::field_array_t       held_fields_reg;
    sfsc_pkg::field_array_t       held_fields_next;
    logic                         header_hit;
    logic                         checksum_ok;
    logic                         store_payload;
    logic [7:0]                   expect_sum;

    // Header match over the two older window bytes and the current one.
    assign header_hit = !collecting_reg
                        && (window_fill_reg == sfsc_pkg::WINDOW_FULL)
                        && (sync_window_reg[15:8] == sfsc_pkg::HDR0)
                        && (sync_window_reg[7:0] == sfsc_pkg::HDR1)
                        && (byte_data == sfsc_pkg::HDR2);

    // The checksum byte arrives once all payload bytes are in.
    assign frame_done    = collecting_reg && (byte_index_reg == sfsc_pkg::LAST_PAYLOAD_IDX);
    assign store_payload = collecting_reg && !frame_done;
    assign expect_sum    = 8'd0 - sum_reg;
    assign checksum_ok   = (expect_sum == byte_data);

    // Next state of the hunt and collect control.
    always_comb
    begin
        sync_window_next = sync_window_reg;
        window_fill_next = window_fill_reg;
        collecting_next  = collecting_reg;
        byte_index_next  = byte_index_reg;
        sum_next         = sum_reg;
        held_fields_next = held_fields_reg;
        if (!collecting_reg)
        begin
            sync_window_next = {sync_window_reg[7:0], byte_data};
            if (window_fill_reg != sfsc_pkg::WINDOW_FULL)
            begin
                window_fill_next = window_fill_reg + 2'd1;
            end
            if (header_hit)
            begin
                collecting_next = 1'b1;
                byte_index_next = '0;
                sum_next        = sync_window_reg[15:8] + sync_window_reg[7:0] + byte_data;
            end
        end
        else if (!frame_done)
        begin
            sum_next        = sum_reg + byte_data;
            byte_index_next = byte_index_reg + sfsc_pkg::IDX_W'(1);
        end
        else
        begin
            if (checksum_ok)
            begin
                held_fields_next = payload_buffer_reg;
            end
            collecting_next  = 1'b0;
            byte_index_next  = '0;
            sum_next         = '0;
            window_fill_next = '0;
            sync_window_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_window_reg <= '0;
            window_fill_reg <= '0;
            collecting_reg  <= 1'b0;
            byte_index_reg  <= '0;
            sum_reg         <= '0;
            held_fields_reg <= '0;
        end
        else if (advance)
        begin
            sync_window_reg <= sync_window_next;
            window_fill_reg <= window_fill_next;
            collecting_reg  <= collecting_next;
            byte_index_reg  <= byte_index_next;
            sum_reg         <= sum_next;
            held_fields_reg <= held_fields_next;
        end
    end

    // Frame payload buffer, written one byte per collected word.
    always_ff @(posedge clk)
    begin
        if (advance && store_payload)
        begin
            payload_buffer_reg[byte_index_reg] <= byte_data;
        end
    end

    // Result shows the held fields as they stand after this frame.
    assign result.status = checksum_ok ? sfsc_pkg::STATUS_GOOD : sfsc_pkg::STATUS_BAD;
    assign result.fields = held_fields_next;

    // The index never passes the checksum position.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= sfsc_pkg::LAST_PAYLOAD_IDX)
        else $error("byte index out of range");

    // While hunting, the index and the running sum stay cleared.
    a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !collecting_reg |-> (byte_index_reg == '0) && (sum_reg == '0))
        else $error("index or sum not cleared while hunting");

    // A finished frame empties the window and returns to hunting.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_done |=> !collecting_reg && (window_fill_reg == '0))
        else $error("frame end did not restart the hunt");

    // A header match starts collecting.
    a_header_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && header_hit |=> collecting_reg && (byte_index_reg == '0))
        else $error("header match did not start collecting");

endmodule

`default_nettype wire

/* sv/sfsc_result_reg.sv */
`default_nettype none

module sfsc_result_reg (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  load,
    input  wire  sfsc_pkg::result_t result,
    output logic can_load,
    output logic out_valid,
    input  wire  out_stall,
    output sfsc_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    sfsc_pkg::result_t result_reg;

    // Space exists when empty or when the waiting word is taken now.
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

/* sv/sensor_frame_sync_checksum_parser.sv */
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_stall    rx_byte (8 bits)
// output    out_valid / out_stall  frame_status, oxygen_level, supply_gear ... sensitivity
//
// A checksum byte's result word is registered in turn: the byte is accepted
// into the input register, the frame core works on it while it sits there, and
// the result register takes the word when the byte moves on.
// A new byte is accepted every cycle while in_stall is low; only the checksum byte makes a result.
// Reset clears the hunt state and zeroes the held fields.
// in_stall rises only when the checksum byte waits on a stalled result word.

module sensor_frame_sync_checksum_parser (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  rx_byte,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        frame_status,
    output logic [15:0] oxygen_level,
    output logic [7:0]  supply_gear,
    output logic [7:0]  supply_mode,
    output logic [7:0]  flow_rate,
    output logic [7:0]  temperature,
    output logic [7:0]  breath_sign,
    output logic [7:0]  breath_rate,
    output logic [7:0]  auto_calibration,
    output logic [7:0]  sensitivity
);

    logic              byte_valid;
    sfsc_pkg::byte_t   byte_data;
    logic              advance;
    logic              frame_done;
    logic              can_load;
    sfsc_pkg::result_t core_result;
    sfsc_pkg::result_t out_result;

    sfsc_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .consume    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // A word moves on unless it ends a frame and the result register is full.
    assign advance = byte_valid && (!frame_done || can_load);

    sfsc_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .byte_data  (byte_data),
        .frame_done (frame_done),
        .result     (core_result)
    );

    sfsc_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && frame_done),
        .result     (core_result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    // Field unpacking, entry 0 is frame byte 3.
    assign frame_status     = out_result.status;
    assign oxygen_level     = {out_result.fields[0], out_result.fields[1]};
    assign supply_gear      = out_result.fields[2];
    assign supply_mode      = out_result.fields[3];
    assign flow_rate        = out_result.fields[4];
    assign temperature      = out_result.fields[5];
    assign breath_sign      = out_result.fields[6];
    assign breath_rate      = out_result.fields[7];
    assign auto_calibration = out_result.fields[8];
    assign sensitivity      = out_result.fields[9];

endmodule

`default_nettype wire
